FILE: rtl/core/cpa_pkg.sv
// shared constants and types for the commandable priority array
package cpa_pkg;

  // default sizes
  localparam int MAX_OBJECTS_DEF     = 8;
  localparam int PRIORITY_LEVELS_DEF = 16;

  // field widths
  localparam int ACTION_W   = 2;
  localparam int INSTANCE_W = 22;
  localparam int LEVEL_W    = 8;
  localparam int VALUE_W    = 32;
  localparam int SLOT_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int ALEVEL_W   = 5;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_COUNT       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELINQUISH_DEFAULT = 1'b1;

  // actions
  localparam logic [ACTION_W-1:0] ACT_COMMAND    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RELINQUISH = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ       = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_BIND       = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RESERVED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd3;

  localparam logic [LEVEL_W-1:0] RESERVED_LEVEL       = 8'd6;
  localparam logic [VALUE_W-1:0] RELINQ_DEFAULT_RESET = 32'd0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEEK,
    S_CMP,
    S_CHK,
    S_ROW,
    S_UPD,
    S_PICK,
    S_VAL_DONE
  } cpa_state_t;

endpackage

FILE: rtl/core/commandable_priority_array.sv
// commandable priority array: instance binding and search, priority update and present value report
// items are handled one at a time: a new item is taken only in S_IDLE, after the last result transfer;
//   the compare loop checks one slot per pass through S_SEEK and S_CMP
// reset: object_count 0, relinquish default 0, all priority rows inactive at once
//   (per-row valid flops); instance and value memories are undefined until written
module commandable_priority_array #(
  parameter int MAX_OBJECTS     = cpa_pkg::MAX_OBJECTS_DEF,
  parameter int PRIORITY_LEVELS = cpa_pkg::PRIORITY_LEVELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [cpa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cpa_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [cpa_pkg::ACTION_W-1:0]        action,
  input  logic [cpa_pkg::INSTANCE_W-1:0]      instance_req,
  input  logic [cpa_pkg::LEVEL_W-1:0]         level,
  input  logic [cpa_pkg::VALUE_W-1:0]         value,
  input  logic [cpa_pkg::SLOT_W-1:0]          slot,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cpa_pkg::STATUS_W-1:0]        status,
  output logic [cpa_pkg::VALUE_W-1:0]         ctrl_value,
  output logic [cpa_pkg::ALEVEL_W-1:0]        active_level
);
  import cpa_pkg::*;

  // slot index, search counter, level index and value memory address widths
  localparam int SW  = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int CW  = $clog2(MAX_OBJECTS + 1);
  localparam int LVW = $clog2(PRIORITY_LEVELS);
  localparam int AW  = $clog2(MAX_OBJECTS * PRIORITY_LEVELS);
  localparam logic [LEVEL_W-1:0] MAX_LEVEL = LEVEL_W'(PRIORITY_LEVELS);

  cpa_state_t state, state_next;

  // configuration registers
  logic [COUNT_W-1:0]    object_count;
  logic [VALUE_W-1:0]    relinquish_default;

  // captured item
  logic [ACTION_W-1:0]   action_q;
  logic [INSTANCE_W-1:0] inst_q;
  logic [LEVEL_W-1:0]    level_q;
  logic [VALUE_W-1:0]    value_q;

  // search and update state
  logic [CW-1:0]         idx;
  logic [SW-1:0]         found;
  logic                  found_ok;
  logic                  do_write;
  logic [PRIORITY_LEVELS-1:0] row_cur;

  // memories and their registered read data
  logic [INSTANCE_W-1:0]      inst_mem [MAX_OBJECTS];
  logic [PRIORITY_LEVELS-1:0] act_mem  [MAX_OBJECTS];
  logic [VALUE_W-1:0]         val_mem  [MAX_OBJECTS * PRIORITY_LEVELS];
  logic [INSTANCE_W-1:0]      inst_rd;
  logic [PRIORITY_LEVELS-1:0] act_rd;
  logic [VALUE_W-1:0]         val_rd;
  logic [MAX_OBJECTS-1:0]     row_ok;   // row written since reset, else all inactive

  // combinational helpers
  logic [CW-1:0]              n_srch;
  logic                       slot_in_range;
  logic                       lvl_reserved;
  logic                       lvl_range;
  logic [LVW-1:0]             lvl_bit;
  logic [PRIORITY_LEVELS-1:0] bit_mask;
  logic [PRIORITY_LEVELS-1:0] row_base;
  logic [PRIORITY_LEVELS-1:0] row_new;
  logic [PRIORITY_LEVELS-1:0] lowest;
  logic [LVW-1:0]             pick_idx;
  logic [AW-1:0]              row_addr;
  logic                       in_xfer;

  // slots searched: object_count clamped to the array size
  assign n_srch = (32'(object_count) > 32'(MAX_OBJECTS)) ? CW'(MAX_OBJECTS)
                                                          : CW'(object_count);
  assign slot_in_range = 32'(slot) < 32'(MAX_OBJECTS);
  assign lvl_reserved  = (level_q == RESERVED_LEVEL);
  assign lvl_range     = (level_q == '0) || (level_q > MAX_LEVEL);
  assign lvl_bit       = LVW'(level_q - LEVEL_W'(1));
  assign bit_mask      = PRIORITY_LEVELS'(1) << lvl_bit;
  assign row_base      = row_ok[found] ? act_rd : '0;
  assign row_new       = (action_q == ACT_COMMAND) ? (row_base | bit_mask)
                                                   : (row_base & ~bit_mask);
  // isolate the lowest active level, then encode it
  assign lowest        = row_cur & (~row_cur + PRIORITY_LEVELS'(1));
  assign row_addr      = AW'(found * PRIORITY_LEVELS);
  assign in_xfer       = in_valid && in_ready;

  always_comb begin
    pick_idx = '0;
    for (int j = 0; j < PRIORITY_LEVELS; j++) begin
      if (lowest[j]) begin
        pick_idx = pick_idx | LVW'(j);
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake outputs
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (action != ACT_BIND) begin
            state_next = S_SEEK;
          end else if (slot_in_range) begin
            state_next = S_ROW;
          end else begin
            state_next = S_VAL_DONE;
          end
        end
      end
      S_SEEK: begin
        // past the last slot means not found
        state_next = (idx < n_srch) ? S_CMP : S_CHK;
      end
      S_CMP: begin
        state_next = (inst_rd == inst_q) ? S_CHK : S_SEEK;
      end
      S_CHK: begin
        state_next = found_ok ? S_ROW : S_VAL_DONE;
      end
      S_ROW: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        state_next = S_PICK;
      end
      S_PICK: begin
        state_next = S_VAL_DONE;
      end
      S_VAL_DONE: begin
        // first cycle after a value read still waits for the read data
        out_valid = !do_write;
        if (!do_write && out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      object_count       <= '0;
      relinquish_default <= RELINQ_DEFAULT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OBJECT_COUNT:       object_count       <= cfg_data[COUNT_W-1:0];
        CFG_RELINQUISH_DEFAULT: relinquish_default <= cfg_data[VALUE_W-1:0];
        default: ;
      endcase
    end
  end

  // row valid bits: a row reads as all inactive until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok <= '0;
    end else if (state == S_UPD && do_write) begin
      row_ok[found] <= 1'b1;
    end
  end

  // instance table: bind writes, search reads
  always_ff @(posedge clk) begin
    if (in_xfer && action == ACT_BIND && slot_in_range) begin
      inst_mem[SW'(slot)] <= instance_req;
    end
    if (state == S_SEEK) begin
      inst_rd <= inst_mem[idx[SW-1:0]];
    end
  end

  // active bit rows
  always_ff @(posedge clk) begin
    if (state == S_UPD && do_write) begin
      act_mem[found] <= row_new;
    end
    if (state == S_ROW) begin
      act_rd <= act_mem[found];
    end
  end

  // commanded values
  always_ff @(posedge clk) begin
    if (state == S_UPD && do_write && action_q == ACT_COMMAND) begin
      val_mem[row_addr + AW'(lvl_bit)] <= value_q;
    end
    if (state == S_PICK) begin
      val_rd <= val_mem[row_addr + AW'(pick_idx)];
    end
  end

  // item capture, search sequencing and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      do_write <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            action_q <= action;
            inst_q   <= instance_req;
            level_q  <= level;
            value_q  <= value;
            idx      <= '0;
            found_ok <= (action == ACT_BIND) && slot_in_range;
            do_write <= 1'b0;
            if (action == ACT_BIND) begin
              found    <= SW'(slot);
              status   <= slot_in_range ? ST_OK : ST_RANGE;
              ctrl_value   <= relinquish_default;
              active_level <= '0;
            end
          end
        end
        S_SEEK: ;
        S_CMP: begin
          // shared compare: one slot per pass, lowest matching slot wins
          if (inst_rd == inst_q) begin
            found    <= idx[SW-1:0];
            found_ok <= 1'b1;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_CHK: begin
          ctrl_value   <= relinquish_default;
          active_level <= '0;
          if (action_q == ACT_READ) begin
            status <= found_ok ? ST_OK : ST_UNKNOWN;
          end else if (lvl_reserved) begin
            status <= ST_RESERVED;
          end else if (lvl_range) begin
            status <= ST_RANGE;
          end else if (!found_ok) begin
            status <= ST_UNKNOWN;
          end else begin
            status   <= ST_OK;
            do_write <= 1'b1;
          end
        end
        S_ROW: ;
        S_UPD: begin
          row_cur  <= do_write ? row_new : row_base;
          do_write <= 1'b0;
        end
        S_PICK: begin
          if (row_cur != '0) begin
            active_level <= ALEVEL_W'(pick_idx) + ALEVEL_W'(1);
            // reuse the write flag to hold off the result for the read cycle
            do_write     <= 1'b1;
          end else begin
            ctrl_value   <= relinquish_default;
            active_level <= '0;
          end
        end
        S_VAL_DONE: begin
          if (do_write) begin
            ctrl_value <= val_rd;
            do_write   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
